### src/height_to_normal_map_unit_assert.svh
// Assertion macros for the height to normal map unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef HEIGHT_TO_NORMAL_MAP_UNIT_ASSERT_SVH
`define HEIGHT_TO_NORMAL_MAP_UNIT_ASSERT_SVH

// same-cycle implication
`define HNM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hnm assertion failed");

// next-cycle implication
`define HNM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hnm assertion failed");

`endif

### src/hnm_pkg.sv
// Shared types and constants of the height to normal map unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hnm_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int HEIGHT_BITS = 16;
	localparam int ALPHA_W     = 8;
	localparam int BYTE_W      = 8;
	localparam int ENTRY_W     = HEIGHT_BITS + ALPHA_W;
	localparam int XW          = $clog2(MAX_WIDTH);
	localparam int WW          = $clog2(MAX_WIDTH + 1);
	localparam int ROW_LIMIT   = 4096;
	localparam int YW          = $clog2(ROW_LIMIT);
	localparam int HW          = $clog2(ROW_LIMIT + 1);

	localparam int STR_W     = 16;
	localparam int FW_W      = 12;
	localparam int FH_W      = 13;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam int GW     = HEIGHT_BITS + 1;
	localparam int PX_W   = HEIGHT_BITS + STR_W;
	localparam int MAG_W  = PX_W + 8;
	localparam int PROD_W = 2 * MAG_W + 18;

	localparam int MZ_SHIFT = 2 * (HEIGHT_BITS + 9);
	localparam logic [PROD_W-1:0] MZ2 = PROD_W'(1) << MZ_SHIFT;
	localparam logic [MAG_W-1:0] BYTE_SCALE2 = MAG_W'(65025);

	localparam logic [STR_W-1:0] STRENGTH_RST = STR_W'(256);
	localparam logic [FW_W-1:0]  FW_RST       = FW_W'(1024);
	localparam logic [FH_W-1:0]  FH_RST       = FH_W'(1024);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STRENGTH     = 2'd0,
		REG_FRAME_WIDTH  = 2'd1,
		REG_FRAME_HEIGHT = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		FE_IDLE,
		FE_READ,
		FE_JOB_A,
		FE_JOB_B,
		FE_JOB_C
	} fe_state_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_GAIN,
		BK_SCALE,
		BK_SQX_GO,
		BK_SQX_W,
		BK_SQY_GO,
		BK_SQY_W,
		BK_SUM,
		BK_A_GO,
		BK_A_W,
		BK_STEP,
		BK_STEP_W,
		BK_OUT
	} be_state_t;

	typedef enum logic [1:0] {
		COMP_X,
		COMP_Y,
		COMP_Z
	} comp_t;

	typedef struct packed {
		logic signed [GW-1:0] gx;
		logic signed [GW-1:0] gy;
		logic [ALPHA_W-1:0]   alpha;
		logic                 last;
	} job_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] a;
		logic [MAG_W-1:0]  b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

endpackage
`default_nettype wire

### src/hnm_job_fifo.sv
// Short job queue between the window front end and the normal back end.
// Depends on hnm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hnm_job_fifo import hnm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	output logic full,
	input  logic pop,
	output logic valid,
	output job_t dout
);

	job_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign valid = cnt_q != '0;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

endmodule
`default_nettype wire

### src/hnm_serial_mul.sv
// Shared shift-and-add multiplier of the back end, one multiplier bit a cycle.
// Depends on hnm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hnm_serial_mul import hnm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic              busy_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] mcand_q;
	logic [MAG_W-1:0]  mplier_q;

	assign rsp.done = busy_q && (mplier_q == '0);
	assign rsp.prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (req.start)
			busy_q <= 1'b1;
		else if (rsp.done)
			busy_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			mcand_q  <= req.a;
			mplier_q <= req.b;
		end else if (busy_q && (mplier_q != '0)) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

endmodule
`default_nettype wire

### src/hnm_front.sv
// Front end: accepts height words, keeps the row stores and window, queues jobs.
// Depends on hnm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hnm_front import hnm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [HEIGHT_BITS-1:0] height_sample,
	input  logic [ALPHA_W-1:0]     alpha_in,
	input  logic [FW_W-1:0]        frame_width,
	input  logic [FH_W-1:0]        frame_height,
	output logic                   job_push,
	output job_t                   job,
	input  logic                   job_full
);

	logic [ENTRY_W-1:0] mid_mem [MAX_WIDTH];
	logic [ENTRY_W-1:0] old_mem [MAX_WIDTH];

	fe_state_t          state_q, state_d;
	logic [ENTRY_W-1:0] cur_q;
	logic [XW-1:0]      x_q;
	logic [YW-1:0]      y_q;
	logic [ENTRY_W-1:0] nw0_q, nw1_q, nw2_q, nw3_q;
	logic [ENTRY_W-1:0] mid_rd_q, midr_rd_q, old_rd_q;

	logic [WW-1:0]      w_eff;
	logic [HW-1:0]      h_eff;
	logic               row_end, last_row, right_ok;
	logic               has_a, has_b, has_c, fin;
	logic [ENTRY_W-1:0] mid, old, ml, mr, upx, lb, lc;
	job_t               job_a, job_b, job_c;

	function automatic logic signed [GW-1:0] hdiff(input logic [ENTRY_W-1:0] p,
		input logic [ENTRY_W-1:0] q);
		hdiff = $signed({1'b0, p[HEIGHT_BITS-1:0]}) - $signed({1'b0, q[HEIGHT_BITS-1:0]});
	endfunction

	always_comb begin
		if (frame_width == '0)
			w_eff = WW'(1);
		else if (32'(frame_width) > MAX_WIDTH)
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(frame_width);
		if (frame_height == '0)
			h_eff = HW'(1);
		else if (32'(frame_height) > ROW_LIMIT)
			h_eff = HW'(ROW_LIMIT);
		else
			h_eff = HW'(frame_height);
	end

	always_comb begin
		row_end  = (32'(x_q) + 1) >= 32'(w_eff);
		last_row = (32'(y_q) + 1) >= 32'(h_eff);
		right_ok = ((32'(x_q) + 1) < 32'(w_eff)) && ((32'(x_q) + 1) < MAX_WIDTH);
		has_a    = y_q != '0;
		has_b    = last_row && (x_q != '0);
		has_c    = last_row && row_end;

		mid = mid_rd_q;
		old = (y_q > YW'(1)) ? old_rd_q : mid;
		ml  = (x_q == '0) ? mid : nw0_q;
		mr  = right_ok ? midr_rd_q : mid;
		upx = has_a ? mid : cur_q;
		lb  = (x_q > XW'(1)) ? nw2_q : nw1_q;
		lc  = (x_q != '0) ? nw1_q : cur_q;

		job_a.gx    = hdiff(mr, ml);
		job_a.gy    = hdiff(cur_q, old);
		job_a.alpha = mid[ENTRY_W-1:HEIGHT_BITS];
		job_a.last  = 1'b0;

		job_b.gx    = hdiff(cur_q, lb);
		job_b.gy    = hdiff(nw1_q, nw3_q);
		job_b.alpha = nw1_q[ENTRY_W-1:HEIGHT_BITS];
		job_b.last  = 1'b0;

		job_c.gx    = hdiff(cur_q, lc);
		job_c.gy    = hdiff(cur_q, upx);
		job_c.alpha = cur_q[ENTRY_W-1:HEIGHT_BITS];
		job_c.last  = 1'b1;

		fin = (state_q == FE_JOB_C) && (!has_c || !job_full);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FE_IDLE: begin
				if (in_valid)
					state_d = FE_READ;
			end
			FE_READ:  state_d = FE_JOB_A;
			FE_JOB_A: begin
				if (!has_a || !job_full)
					state_d = FE_JOB_B;
			end
			FE_JOB_B: begin
				if (!has_b || !job_full)
					state_d = FE_JOB_C;
			end
			FE_JOB_C: begin
				if (!has_c || !job_full)
					state_d = FE_IDLE;
			end
			default:  state_d = FE_IDLE;
		endcase
	end

	always_comb begin
		in_stall = state_q != FE_IDLE;
		job_push = 1'b0;
		job      = job_a;
		unique case (state_q)
			FE_JOB_A: job_push = has_a && !job_full;
			FE_JOB_B: begin
				job_push = has_b && !job_full;
				job      = job_b;
			end
			FE_JOB_C: begin
				job_push = has_c && !job_full;
				job      = job_c;
			end
			default: job_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			nw0_q   <= '0;
			nw1_q   <= '0;
			nw2_q   <= '0;
			nw3_q   <= '0;
		end else begin
			state_q <= state_d;
			if (fin) begin
				if (has_a)
					nw0_q <= mid;
				nw2_q <= nw1_q;
				nw1_q <= cur_q;
				nw3_q <= upx;
				if (row_end) begin
					x_q <= '0;
					y_q <= last_row ? '0 : y_q + 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == FE_IDLE) && in_valid)
			cur_q <= {alpha_in, height_sample};
		if (state_q == FE_READ) begin
			mid_rd_q  <= mid_mem[x_q];
			midr_rd_q <= mid_mem[x_q + 1'b1];
			old_rd_q  <= old_mem[x_q];
		end
		if (fin) begin
			if (has_a)
				old_mem[x_q] <= mid;
			mid_mem[x_q] <= cur_q;
		end
	end

endmodule
`default_nettype wire

### src/hnm_back.sv
// Back end: scales gradients, normalizes and maps each component to a byte.
// Depends on hnm_pkg; drives the shared serial multiplier.
`timescale 1ns / 1ps
`default_nettype none
module hnm_back import hnm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [STR_W-1:0]   strength,
	input  logic               job_valid,
	input  job_t               job,
	output logic               job_pop,
	output mul_req_t           mul_req,
	input  mul_rsp_t           mul_rsp,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [BYTE_W-1:0]  normal_x,
	output logic [BYTE_W-1:0]  normal_y,
	output logic [BYTE_W-1:0]  normal_z,
	output logic [ALPHA_W-1:0] alpha_out,
	output logic               last_of_frame
);

	be_state_t             state_q, state_d;
	comp_t                 comp_q;
	logic [HEIGHT_BITS-1:0] ax_q, ay_q;
	logic                  negx_q, negy_q, last_q, tneg_q;
	logic [ALPHA_W-1:0]    alpha_q;
	logic [PX_W-1:0]       px_q, py_q;
	logic [MAG_W-1:0]      mx_q, my_q;
	logic [PROD_W-1:0]     sqx_q, sqy_q, l2_q, a65_q;
	logic [BYTE_W-1:0]     lo_q, hi_q, m_q, bx_q, by_q, bz_q;
	logic                  out_valid_q;
	logic [BYTE_W-1:0]     nx_q, ny_q, nz_q;
	logic [ALPHA_W-1:0]    na_q;
	logic                  nl_q;

	logic [PROD_W-1:0]     a2_sel;
	logic                  mag_zero, neg_sel;
	logic [BYTE_W:0]       sum9;
	logic [BYTE_W-1:0]     mid_m;
	logic signed [9:0]     t_s;
	logic                  t_neg, t_zero, quick, quick_ok, slow_ok, take;
	logic [8:0]            t_abs;
	logic [16:0]           tt;

	assign out_valid     = out_valid_q;
	assign normal_x      = nx_q;
	assign normal_y      = ny_q;
	assign normal_z      = nz_q;
	assign alpha_out     = na_q;
	assign last_of_frame = nl_q;

	always_comb begin
		case (comp_q)
			COMP_X: begin
				a2_sel   = sqx_q;
				mag_zero = mx_q == '0;
				neg_sel  = negx_q;
			end
			COMP_Y: begin
				a2_sel   = sqy_q;
				mag_zero = my_q == '0;
				neg_sel  = negy_q;
			end
			default: begin
				a2_sel   = MZ2;
				mag_zero = 1'b0;
				neg_sel  = 1'b0;
			end
		endcase
		sum9     = {1'b0, lo_q} + {1'b0, hi_q} + 1'b1;
		mid_m    = sum9[BYTE_W:1];
		t_s      = $signed({1'b0, mid_m, 1'b0}) - 10'sd256;
		t_neg    = t_s[9];
		t_zero   = t_s == 10'sd0;
		t_abs    = t_neg ? 9'(-t_s) : t_s[8:0];
		tt       = 17'(t_abs) * 17'(t_abs);
		quick    = t_zero || (t_neg && (mag_zero || !neg_sel)) ||
			(!t_neg && (mag_zero || neg_sel));
		quick_ok = t_zero ? (mag_zero || !neg_sel) : t_neg;
		slow_ok  = tneg_q ? (mul_rsp.prod >= a65_q) : (mul_rsp.prod <= a65_q);
		take     = !out_valid_q || !out_stall;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid)
					state_d = BK_GAIN;
			end
			BK_GAIN:   state_d = BK_SCALE;
			BK_SCALE:  state_d = BK_SQX_GO;
			BK_SQX_GO: state_d = BK_SQX_W;
			BK_SQX_W: begin
				if (mul_rsp.done)
					state_d = BK_SQY_GO;
			end
			BK_SQY_GO: state_d = BK_SQY_W;
			BK_SQY_W: begin
				if (mul_rsp.done)
					state_d = BK_SUM;
			end
			BK_SUM:    state_d = BK_A_GO;
			BK_A_GO:   state_d = BK_A_W;
			BK_A_W: begin
				if (mul_rsp.done)
					state_d = BK_STEP;
			end
			BK_STEP: begin
				if (lo_q == hi_q)
					state_d = (comp_q == COMP_Z) ? BK_OUT : BK_A_GO;
				else if (!quick)
					state_d = BK_STEP_W;
			end
			BK_STEP_W: begin
				if (mul_rsp.done)
					state_d = BK_STEP;
			end
			BK_OUT: begin
				if (take)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop       = 1'b0;
		mul_req.start = 1'b0;
		mul_req.a     = l2_q;
		mul_req.b     = MAG_W'(tt);
		unique case (state_q)
			BK_IDLE: job_pop = job_valid;
			BK_SQX_GO: begin
				mul_req.start = 1'b1;
				mul_req.a     = PROD_W'(mx_q);
				mul_req.b     = mx_q;
			end
			BK_SQY_GO: begin
				mul_req.start = 1'b1;
				mul_req.a     = PROD_W'(my_q);
				mul_req.b     = my_q;
			end
			BK_A_GO: begin
				mul_req.start = 1'b1;
				mul_req.a     = a2_sel;
				mul_req.b     = BYTE_SCALE2;
			end
			BK_STEP: mul_req.start = (lo_q != hi_q) && !quick;
			default: job_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == BK_OUT) && take)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					ax_q    <= HEIGHT_BITS'(job.gx[GW-1] ? -job.gx : job.gx);
					ay_q    <= HEIGHT_BITS'(job.gy[GW-1] ? -job.gy : job.gy);
					negx_q  <= !job.gx[GW-1] && (job.gx != '0);
					negy_q  <= !job.gy[GW-1] && (job.gy != '0);
					alpha_q <= job.alpha;
					last_q  <= job.last;
				end
			end
			BK_GAIN: begin
				px_q <= PX_W'(ax_q) * PX_W'(strength);
				py_q <= PX_W'(ay_q) * PX_W'(strength);
			end
			BK_SCALE: begin
				mx_q <= (MAG_W'(px_q) << 8) - MAG_W'(px_q);
				my_q <= (MAG_W'(py_q) << 8) - MAG_W'(py_q);
			end
			BK_SQX_W: begin
				if (mul_rsp.done)
					sqx_q <= mul_rsp.prod;
			end
			BK_SQY_W: begin
				if (mul_rsp.done)
					sqy_q <= mul_rsp.prod;
			end
			BK_SUM: begin
				l2_q   <= sqx_q + sqy_q + MZ2;
				comp_q <= COMP_X;
			end
			BK_A_W: begin
				if (mul_rsp.done) begin
					a65_q <= mul_rsp.prod;
					lo_q  <= '0;
					hi_q  <= '1;
				end
			end
			BK_STEP: begin
				if (lo_q == hi_q) begin
					case (comp_q)
						COMP_X: begin
							bx_q   <= lo_q;
							comp_q <= COMP_Y;
						end
						COMP_Y: begin
							by_q   <= lo_q;
							comp_q <= COMP_Z;
						end
						default: bz_q <= lo_q;
					endcase
				end else if (quick) begin
					if (quick_ok)
						lo_q <= mid_m;
					else
						hi_q <= mid_m - 1'b1;
				end else begin
					tneg_q <= t_neg;
					m_q    <= mid_m;
				end
			end
			BK_STEP_W: begin
				if (mul_rsp.done) begin
					if (slow_ok)
						lo_q <= m_q;
					else
						hi_q <= m_q - 1'b1;
				end
			end
			BK_OUT: begin
				if (take) begin
					nx_q <= bx_q;
					ny_q <= by_q;
					nz_q <= bz_q;
					na_q <= alpha_q;
					nl_q <= last_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### src/height_to_normal_map_unit.sv
// Height map to normal map unit, top level: configuration registers and wiring.
// Depends on hnm_pkg, hnm_front, hnm_job_fifo, hnm_back, hnm_serial_mul.
//
// Input words (height_sample, alpha_in) arrive in raster order on in_valid/in_stall;
// normal words (normal_x/y/z, alpha_out, last_of_frame) leave on out_valid/out_stall.
// A word moves at a clock edge with valid high and stall low.
// Results lag the input by one row; the words of the last row also flush that row,
// and the final word of a frame carries last_of_frame.
// The front end takes one input word, then stalls in FE_READ and FE_JOB_A/B/C, and
// longer while the four-entry job queue is full. Each result is worked out by the
// back end, one job at a time, on one bit-serial multiplier; that multiplier sets
// the sustained rate.
// Write strength, frame_width and frame_height through cfg_wr_en, cfg_index and
// cfg_data only while the unit is idle.
// Reset clears the counters, the neighbor window and the handshakes; the row
// stores need no clearing. A stalled receiver holds the output word, then the
// back end, then the queue, then in_stall.
`timescale 1ns / 1ps
`default_nettype none
`include "height_to_normal_map_unit_assert.svh"
module height_to_normal_map_unit import hnm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [HEIGHT_BITS-1:0] height_sample,
	input  logic [ALPHA_W-1:0]     alpha_in,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [BYTE_W-1:0]      normal_x,
	output logic [BYTE_W-1:0]      normal_y,
	output logic [BYTE_W-1:0]      normal_z,
	output logic [ALPHA_W-1:0]     alpha_out,
	output logic                   last_of_frame
);

	logic [STR_W-1:0] strength_q;
	logic [FW_W-1:0]  frame_width_q;
	logic [FH_W-1:0]  frame_height_q;

	logic     job_push, job_full, job_pop, job_valid;
	job_t     job_in, job_out;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q     <= STRENGTH_RST;
			frame_width_q  <= FW_RST;
			frame_height_q <= FH_RST;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_STRENGTH:     strength_q     <= cfg_data[STR_W-1:0];
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	hnm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.height_sample (height_sample),
		.alpha_in      (alpha_in),
		.frame_width   (frame_width_q),
		.frame_height  (frame_height_q),
		.job_push      (job_push),
		.job           (job_in),
		.job_full      (job_full)
	);

	hnm_job_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.valid  (job_valid),
		.dout   (job_out)
	);

	hnm_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	hnm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.strength      (strength_q),
		.job_valid     (job_valid),
		.job           (job_out),
		.job_pop       (job_pop),
		.mul_req       (mul_req),
		.mul_rsp       (mul_rsp),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.normal_x      (normal_x),
		.normal_y      (normal_y),
		.normal_z      (normal_z),
		.alpha_out     (alpha_out),
		.last_of_frame (last_of_frame)
	);

	`HNM_ASSERT_SAME(a_push_has_room, job_push, !job_full)
	`HNM_ASSERT_SAME(a_pop_has_job, job_pop, job_valid)
	`HNM_ASSERT_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall)

endmodule
`default_nettype wire
